### rtl/zpc_pkg.sv
// Shared types, constants and fixed-point helpers for the Zernike phase correction block.
`timescale 1ns / 1ps

package zpc_pkg;

    localparam int COEFF_SLOTS = 16;
    localparam int MODE_SLOTS  = 16;
    localparam int QUARTER_PI_Q16 = 51472;
    localparam int HALF_PI_Q16    = 102944;
    localparam int CORDIC_STEPS   = 16;
    localparam int CORDIC_GAIN_INV = 39797;
    localparam int Q16_ONE        = 65536;

    typedef enum logic [3:0] {
        CFG_CENTER_X   = 4'd0,
        CFG_CENTER_Y   = 4'd1,
        CFG_INV_RADIUS = 4'd2,
        CFG_MODE_COUNT = 4'd3,
        CFG_COEFF_0    = 4'd4,
        CFG_COEFF_1    = 4'd5,
        CFG_COEFF_2    = 4'd6,
        CFG_COEFF_3    = 4'd7
    } t_cfg_reg;

    // Radial polynomial kinds that occur among the first sixteen modes.
    typedef enum logic [2:0] {
        POLY_ONE = 3'd0,
        POLY_20  = 3'd1,
        POLY_31  = 3'd2,
        POLY_42  = 3'd3,
        POLY_40  = 3'd4
    } t_poly;

    typedef struct packed {
        logic [9:0]         pixel_x;
        logic [9:0]         pixel_y;
        logic signed [15:0] field_real;
        logic signed [15:0] field_imag;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] corrected_real;
        logic signed [15:0] corrected_imag;
        logic signed [15:0] phase_value;
        logic               inside_pupil;
    } t_out_item;

    typedef struct packed {
        logic signed [15:0] phase_value;
        logic               inside_pupil;
        logic signed [15:0] field_real;
        logic signed [15:0] field_imag;
    } t_phase_item;

    typedef struct packed {
        logic [13:0]      center_x;
        logic [13:0]      center_y;
        logic [23:0]      inv_radius;
        logic [4:0]       mode_count;
        logic [3:0][63:0] coeff_word;
    } t_cfg;

    // Mode order: n ascending, m from -n to n in steps of 2.
    localparam logic [2:0] MODE_POW [0:15] = '{
        3'd0, 3'd1, 3'd1, 3'd2, 3'd0, 3'd2, 3'd3, 3'd1,
        3'd1, 3'd3, 3'd4, 3'd2, 3'd0, 3'd2, 3'd4, 3'd5
    };

    // Sine-type modes (m < 0) take the imaginary part of (x + iy)^|m|.
    localparam logic MODE_IM [0:15] = '{
        1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1,
        1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1
    };

    localparam t_poly MODE_POLY [0:15] = '{
        POLY_ONE, POLY_ONE, POLY_ONE, POLY_ONE, POLY_20, POLY_ONE, POLY_ONE, POLY_31,
        POLY_31, POLY_ONE, POLY_ONE, POLY_42, POLY_40, POLY_42, POLY_ONE, POLY_ONE
    };

    localparam logic signed [21:0] ATAN_TAB [0:15] = '{
        22'sd51472, 22'sd30386, 22'sd16055, 22'sd8150, 22'sd4091, 22'sd2047,
        22'sd1024, 22'sd512, 22'sd256, 22'sd128, 22'sd64, 22'sd32,
        22'sd16, 22'sd8, 22'sd4, 22'sd2
    };

    // Shift right by s with rounding to nearest, ties away from zero.
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int unsigned s);
        logic [63:0] mag;
        logic [63:0] q;
        mag = v[63] ? 64'(-v) : 64'(v);
        q = (mag + (64'd1 << (s - 1))) >> s;
        rnd_shift = v[63] ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -64'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = $signed(v[15:0]);
        end
        sat16 = r;
    endfunction

endpackage

### rtl/zernike_phase_correction.sv
// Top level of the Zernike phase correction block: configuration registers and flow control.
// An accepted item passes through the phase pipeline and then the rotation pipeline.
// Throughput is one item per cycle; the whole pipeline moves together and holds when the
// output register is full and not taken.
// Synchronous active-low reset clears every valid bit and loads the register defaults.
`timescale 1ns / 1ps

module zernike_phase_correction #(
    parameter int IMAGE_WIDTH  = 1024,
    parameter int IMAGE_HEIGHT = 1024,
    parameter int MAX_MODES    = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  zpc_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output zpc_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [3:0]          i_cfg_index,
    input  logic [63:0]         i_cfg_data
);

    // The user must change configuration only while the pipeline is empty (the block does not
    // enforce this), so the stages read these registers directly without any shadow copy.
    zpc_pkg::t_cfg r_cfg;

    // One enable for every stage: the pipeline advances whenever the final
    // output register is empty or its item is being taken this cycle. Bubbles
    // travel as cleared valid bits, so nothing is lost or repeated on a stall.
    logic en;

    logic                 ph_valid;
    zpc_pkg::t_phase_item ph_item;

    assign en          = !o_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x   <= 14'd8192;
            r_cfg.center_y   <= 14'd8192;
            r_cfg.inv_radius <= 24'd32768;
            r_cfg.mode_count <= 5'd0;
            r_cfg.coeff_word <= '0;
        end else if (i_cfg_valid) begin
            // Writes to indexes outside the register list are dropped.
            case (i_cfg_index)
                zpc_pkg::CFG_CENTER_X:   r_cfg.center_x      <= i_cfg_data[13:0];
                zpc_pkg::CFG_CENTER_Y:   r_cfg.center_y      <= i_cfg_data[13:0];
                zpc_pkg::CFG_INV_RADIUS: r_cfg.inv_radius    <= i_cfg_data[23:0];
                zpc_pkg::CFG_MODE_COUNT: r_cfg.mode_count    <= i_cfg_data[4:0];
                zpc_pkg::CFG_COEFF_0:    r_cfg.coeff_word[0] <= i_cfg_data;
                zpc_pkg::CFG_COEFF_1:    r_cfg.coeff_word[1] <= i_cfg_data;
                zpc_pkg::CFG_COEFF_2:    r_cfg.coeff_word[2] <= i_cfg_data;
                zpc_pkg::CFG_COEFF_3:    r_cfg.coeff_word[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The phase pipeline normalizes the pixel position and forms the weighted
    // sum of the enabled modes; pixels outside the pupil or the image get zero.
    zpc_phase #(
        .IMAGE_WIDTH (IMAGE_WIDTH),
        .IMAGE_HEIGHT(IMAGE_HEIGHT),
        .MAX_MODES   (MAX_MODES)
    ) u_phase (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(i_in_valid),
        .i_item (i_in_item),
        .i_cfg  (r_cfg),
        .o_valid(ph_valid),
        .o_item (ph_item)
    );

    // The rotation pipeline turns the field by minus the phase; its last stage
    // is the output register seen on the result channel.
    zpc_cordic u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(ph_valid),
        .i_item (ph_item),
        .o_valid(o_out_valid),
        .o_item (o_out_item)
    );

endmodule

### rtl/zpc_phase.sv
// Phase pipeline: coordinate normalization, Zernike mode evaluation and the weighted sum.
`timescale 1ns / 1ps

module zpc_phase #(
    parameter int IMAGE_WIDTH  = 1024,
    parameter int IMAGE_HEIGHT = 1024,
    parameter int MAX_MODES    = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  zpc_pkg::t_in_item     i_item,
    input  zpc_pkg::t_cfg         i_cfg,
    output logic                  o_valid,
    output zpc_pkg::t_phase_item  o_item
);

    localparam int LIM_CAP = (MAX_MODES < zpc_pkg::COEFF_SLOTS) ? MAX_MODES
                                                                 : zpc_pkg::COEFF_SLOTS;

    function automatic logic signed [19:0] cmul_re(input logic signed [19:0] ar,
                                                   input logic signed [19:0] ai,
                                                   input logic signed [19:0] br,
                                                   input logic signed [19:0] bi);
        cmul_re = 20'(zpc_pkg::rnd_shift(64'(ar * br) - 64'(ai * bi), 16));
    endfunction

    function automatic logic signed [19:0] cmul_im(input logic signed [19:0] ar,
                                                   input logic signed [19:0] ai,
                                                   input logic signed [19:0] br,
                                                   input logic signed [19:0] bi);
        cmul_im = 20'(zpc_pkg::rnd_shift(64'(ar * bi) + 64'(ai * br), 16));
    endfunction

    logic [10:1] r_vld;
    logic signed [15:0] r_fr [1:9];
    logic signed [15:0] r_fi [1:9];

    // Stage 1: offsets from the center and scaling by the reciprocal radius.
    logic signed [14:0] n_dx, n_dy;
    logic [13:0] n_magx, n_magy;
    logic [37:0] r1_prodx, r1_prody;
    logic r1_negx, r1_negy, r1_oob;

    // Stage 2: rounded normalized coordinates.
    logic [26:0] n_qx, n_qy;
    logic signed [17:0] r2_xn, r2_yn;
    logic r2_out;

    // Stage 3 to 6: squares, radius, radial polynomials and complex powers.
    logic [33:0] r3_sqx, r3_sqy;
    logic r3_out;
    logic signed [19:0] r3_pr [1:2];
    logic signed [19:0] r3_pi [1:2];
    logic signed [19:0] n_x1, n_y1;

    logic [34:0] n_rr;
    logic r4_inside;
    logic [16:0] r4_r2;
    logic signed [19:0] r4_pr [1:3];
    logic signed [19:0] r4_pi [1:3];

    logic r5_inside;
    logic [16:0] r5_r2, r5_pw2;
    logic signed [19:0] r5_pr [1:4];
    logic signed [19:0] r5_pi [1:4];

    logic signed [20:0] n_r2s, n_pw2s;
    logic r6_inside;
    logic signed [20:0] r6_poly [0:4];
    logic signed [19:0] r6_pr [1:5];
    logic signed [19:0] r6_pi [1:5];

    // Stage 7 to 10: mode values, weighted terms and the sum tree.
    logic signed [19:0] n_cr [0:5];
    logic signed [19:0] n_ci [0:5];
    logic signed [20:0] n_z [0:15];
    logic r7_inside;
    logic signed [20:0] r7_z [0:15];

    logic [4:0] n_lim;
    logic signed [36:0] n_term [0:15];
    logic r8_inside;
    logic signed [36:0] r8_term [0:15];

    logic signed [38:0] n_grp [0:3];
    logic r9_inside;
    logic signed [38:0] r9_grp [0:3];

    logic signed [40:0] n_tot;
    logic signed [15:0] n_phase;
    zpc_pkg::t_phase_item r10_item;

    always_comb begin
        n_dx = $signed({1'b0, i_item.pixel_x, 4'b0000}) - $signed({1'b0, i_cfg.center_x});
        n_dy = $signed({1'b0, i_item.pixel_y, 4'b0000}) - $signed({1'b0, i_cfg.center_y});
        n_magx = n_dx[14] ? 14'(-n_dx) : n_dx[13:0];
        n_magy = n_dy[14] ? 14'(-n_dy) : n_dy[13:0];
        n_qx = 27'((r1_prodx + 38'd2048) >> 12);
        n_qy = 27'((r1_prody + 38'd2048) >> 12);
        n_x1 = 20'(r2_xn);
        n_y1 = 20'(r2_yn);
        n_rr = 35'(r3_sqx) + 35'(r3_sqy);
        n_r2s = $signed({4'b0000, r5_r2});
        n_pw2s = $signed({4'b0000, r5_pw2});
        n_lim = (i_cfg.mode_count > 5'(LIM_CAP)) ? 5'(LIM_CAP) : i_cfg.mode_count;
        n_cr[0] = 20'sd65536;
        n_ci[0] = 20'sd0;
        for (int k = 1; k <= 5; k++) begin
            n_cr[k] = r6_pr[k];
            n_ci[k] = r6_pi[k];
        end
        for (int g = 0; g < 4; g++) begin
            n_grp[g] = 39'(r8_term[4 * g]) + 39'(r8_term[4 * g + 1])
                     + 39'(r8_term[4 * g + 2]) + 39'(r8_term[4 * g + 3]);
        end
        n_tot = 41'(r9_grp[0]) + 41'(r9_grp[1]) + 41'(r9_grp[2]) + 41'(r9_grp[3]);
        n_phase = r9_inside ? zpc_pkg::sat16(zpc_pkg::rnd_shift(64'(n_tot), 16)) : 16'sd0;
    end

    for (genvar j = 0; j < zpc_pkg::MODE_SLOTS; j++) begin : g_mode
        logic signed [19:0] comp;
        logic signed [15:0] coef;
        assign comp = zpc_pkg::MODE_IM[j] ? n_ci[zpc_pkg::MODE_POW[j]]
                                          : n_cr[zpc_pkg::MODE_POW[j]];
        assign n_z[j] = 21'(zpc_pkg::rnd_shift(
            64'(r6_poly[zpc_pkg::MODE_POLY[j]] * comp), 16));
        assign coef = $signed(i_cfg.coeff_word[j / 4][16 * (j % 4) +: 16]);
        assign n_term[j] = (5'(j) < n_lim) ? 37'(coef * r7_z[j]) : 37'sd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[9:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fr[1] <= i_item.field_real;
            r_fi[1] <= i_item.field_imag;
            for (int s = 2; s <= 9; s++) begin
                r_fr[s] <= r_fr[s - 1];
                r_fi[s] <= r_fi[s - 1];
            end

            r1_prodx <= 38'(n_magx) * 38'(i_cfg.inv_radius);
            r1_prody <= 38'(n_magy) * 38'(i_cfg.inv_radius);
            r1_negx  <= n_dx[14];
            r1_negy  <= n_dy[14];
            r1_oob   <= ({3'b000, i_item.pixel_x} >= 13'(IMAGE_WIDTH))
                     || ({3'b000, i_item.pixel_y} >= 13'(IMAGE_HEIGHT));

            r2_xn  <= r1_negx ? -$signed({1'b0, n_qx[16:0]}) : $signed({1'b0, n_qx[16:0]});
            r2_yn  <= r1_negy ? -$signed({1'b0, n_qy[16:0]}) : $signed({1'b0, n_qy[16:0]});
            r2_out <= r1_oob || (n_qx > 27'd65536) || (n_qy > 27'd65536);

            r3_sqx   <= 34'(r2_xn * r2_xn);
            r3_sqy   <= 34'(r2_yn * r2_yn);
            r3_out   <= r2_out;
            r3_pr[1] <= n_x1;
            r3_pi[1] <= n_y1;
            r3_pr[2] <= cmul_re(n_x1, n_y1, n_x1, n_y1);
            r3_pi[2] <= cmul_im(n_x1, n_y1, n_x1, n_y1);

            r4_inside <= !r3_out && (n_rr <= 35'h1_0000_0000);
            r4_r2     <= 17'((n_rr + 35'd32768) >> 16);
            r4_pr[1:2] <= r3_pr[1:2];
            r4_pi[1:2] <= r3_pi[1:2];
            r4_pr[3]  <= cmul_re(r3_pr[2], r3_pi[2], r3_pr[1], r3_pi[1]);
            r4_pi[3]  <= cmul_im(r3_pr[2], r3_pi[2], r3_pr[1], r3_pi[1]);

            r5_inside <= r4_inside;
            r5_r2     <= r4_r2;
            r5_pw2    <= 17'((34'(r4_r2) * 34'(r4_r2) + 34'd32768) >> 16);
            r5_pr[1:3] <= r4_pr[1:3];
            r5_pi[1:3] <= r4_pi[1:3];
            r5_pr[4]  <= cmul_re(r4_pr[3], r4_pi[3], r4_pr[1], r4_pi[1]);
            r5_pi[4]  <= cmul_im(r4_pr[3], r4_pi[3], r4_pr[1], r4_pi[1]);

            r6_inside <= r5_inside;
            r6_poly[zpc_pkg::POLY_ONE] <= 21'sd65536;
            r6_poly[zpc_pkg::POLY_20]  <= 21'sd2 * n_r2s - 21'sd65536;
            r6_poly[zpc_pkg::POLY_31]  <= 21'sd3 * n_r2s - 21'sd131072;
            r6_poly[zpc_pkg::POLY_42]  <= 21'sd4 * n_r2s - 21'sd196608;
            r6_poly[zpc_pkg::POLY_40]  <= 21'sd6 * n_pw2s - 21'sd6 * n_r2s + 21'sd65536;
            r6_pr[1:4] <= r5_pr[1:4];
            r6_pi[1:4] <= r5_pi[1:4];
            r6_pr[5]  <= cmul_re(r5_pr[4], r5_pi[4], r5_pr[1], r5_pi[1]);
            r6_pi[5]  <= cmul_im(r5_pr[4], r5_pi[4], r5_pr[1], r5_pi[1]);

            r7_inside <= r6_inside;
            r7_z      <= n_z;

            r8_inside <= r7_inside;
            r8_term   <= n_term;

            r9_inside <= r8_inside;
            r9_grp    <= n_grp;

            r10_item.phase_value  <= n_phase;
            r10_item.inside_pupil <= r9_inside;
            r10_item.field_real   <= r_fr[9];
            r10_item.field_imag   <= r_fi[9];
        end
    end

    assign o_valid = r_vld[10];
    assign o_item  = r10_item;

endmodule

### rtl/zpc_cordic.sv
// Rotation pipeline: quarter-turn reduction, sixteen CORDIC stages, gain and saturation.
`timescale 1ns / 1ps

module zpc_cordic (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  zpc_pkg::t_phase_item  i_item,
    output logic                  o_valid,
    output zpc_pkg::t_out_item    o_item
);

    localparam int NSTAGE = zpc_pkg::CORDIC_STEPS + 4;
    localparam int NTHR = 11;

    logic [NSTAGE-1:0] r_vld;

    logic signed [21:0] n_zin;
    logic [3:0] n_kp, n_kn;
    logic signed [21:0] r0_z;
    logic [3:0] r0_k;
    logic r0_neg;
    zpc_pkg::t_phase_item r0_item;

    logic signed [21:0] n_kh;
    logic [1:0] n_rot;
    logic signed [16:0] n_fr, n_fi, n_xr, n_yr;

    logic signed [35:0] r_x [0:zpc_pkg::CORDIC_STEPS];
    logic signed [35:0] r_y [0:zpc_pkg::CORDIC_STEPS];
    logic signed [21:0] r_z [0:zpc_pkg::CORDIC_STEPS];
    zpc_pkg::t_phase_item r_it [0:zpc_pkg::CORDIC_STEPS];

    logic signed [53:0] r_gx, r_gy;
    zpc_pkg::t_phase_item r_git;
    zpc_pkg::t_out_item r_out;

    always_comb begin
        n_zin = -(22'(i_item.phase_value) <<< 5);
        n_kp = '0;
        n_kn = '0;
        for (int j = 0; j < NTHR; j++) begin
            n_kp = n_kp + 4'(n_zin >
                22'(zpc_pkg::QUARTER_PI_Q16 + j * zpc_pkg::HALF_PI_Q16));
            n_kn = n_kn + 4'(n_zin <
                -22'(zpc_pkg::QUARTER_PI_Q16 + j * zpc_pkg::HALF_PI_Q16));
        end

        n_kh  = 22'($signed({1'b0, r0_k}) * 22'sd102944);
        n_rot = r0_neg ? 2'(-r0_k[1:0]) : r0_k[1:0];
        n_fr  = 17'(r0_item.field_real);
        n_fi  = 17'(r0_item.field_imag);
        case (n_rot)
            2'd0: begin
                n_xr = n_fr;
                n_yr = n_fi;
            end
            2'd1: begin
                n_xr = -n_fi;
                n_yr = n_fr;
            end
            2'd2: begin
                n_xr = -n_fr;
                n_yr = -n_fi;
            end
            default: begin
                n_xr = n_fi;
                n_yr = -n_fr;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NSTAGE-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_z    <= n_zin;
            r0_k    <= n_kp + n_kn;
            r0_neg  <= n_zin[21];
            r0_item <= i_item;

            r_x[0]  <= 36'(n_xr) <<< 16;
            r_y[0]  <= 36'(n_yr) <<< 16;
            r_z[0]  <= r0_neg ? r0_z + n_kh : r0_z - n_kh;
            r_it[0] <= r0_item;

            r_gx  <= r_x[zpc_pkg::CORDIC_STEPS] * 54'sd39797;
            r_gy  <= r_y[zpc_pkg::CORDIC_STEPS] * 54'sd39797;
            r_git <= r_it[zpc_pkg::CORDIC_STEPS];

            if (r_git.phase_value == 16'sd0) begin
                r_out.corrected_real <= r_git.field_real;
                r_out.corrected_imag <= r_git.field_imag;
            end else begin
                r_out.corrected_real <= zpc_pkg::sat16(zpc_pkg::rnd_shift(64'(r_gx), 32));
                r_out.corrected_imag <= zpc_pkg::sat16(zpc_pkg::rnd_shift(64'(r_gy), 32));
            end
            r_out.phase_value  <= r_git.phase_value;
            r_out.inside_pupil <= r_git.inside_pupil;
        end
    end

    for (genvar i = 0; i < zpc_pkg::CORDIC_STEPS; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_z[i] >= 22'sd0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - zpc_pkg::ATAN_TAB[i];
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + zpc_pkg::ATAN_TAB[i];
                end
                r_it[i+1] <= r_it[i];
            end
        end
    end

    assign o_valid = r_vld[NSTAGE-1];
    assign o_item  = r_out;

endmodule

### rtl/zpc_checker.sv
// Port-level assertions for the Zernike phase correction block and their bind.
`timescale 1ns / 1ps

module zpc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input zpc_pkg::t_out_item  o_out_item
);

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.inside_pupil |-> o_out_item.phase_value == 16'sd0)
        else $error("phase is not zero outside the pupil");

    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind zernike_phase_correction zpc_checker u_zpc_checker (.*);

### verif/tb.sv
// Self-checking testbench for the Zernike phase correction block, with directed and random pixels.
`timescale 1ns / 1ps

module tb;

    // Cycles with no handshake on any channel before the run is declared hung.
    localparam int HANG_LIMIT = 20000;
    // The pipeline is 30 deep; this margin covers it before registers change.
    localparam int SETTLE_CYCLES = 40;
    // An index that maps to no register; writes to it must be ignored.
    localparam logic [3:0] UNMAPPED_REG = 4'd12;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    zpc_pkg::t_in_item   i_in_item = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    zpc_pkg::t_out_item  o_out_item;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [3:0]          i_cfg_index = '0;
    logic [63:0]         i_cfg_data = '0;

    zernike_phase_correction dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The testbench's own copy of the register file.
    logic [13:0]      pupil_cx;
    logic [13:0]      pupil_cy;
    logic [23:0]      pupil_inv_r;
    logic [4:0]       modes_used;
    logic [3:0][63:0] coeff_words;

    zpc_pkg::t_out_item pending_results[$];
    int        mismatch_count = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        quiet_cycles = 0;

    // Shift right with rounding to nearest, ties away from zero.
    function automatic longint round_shift(longint v, int s);
        longint half;
        half = longint'(1) << (s - 1);
        if (v >= 0) begin
            return (v + half) >>> s;
        end
        return -((-v + half) >>> s);
    endfunction

    function automatic longint clip16(longint v);
        if (v > 32767) begin
            return 32767;
        end
        if (v < -32768) begin
            return -32768;
        end
        return v;
    endfunction

    function automatic longint factorial(int k);
        longint f;
        f = 1;
        for (int i = 2; i <= k; i++) begin
            f = f * i;
        end
        return f;
    endfunction

    // Pixel coordinate to a Q16 pupil coordinate; the magnitude is rounded so the sign is symmetric.
    function automatic longint pupil_coord(logic [9:0] pix, logic [13:0] ctr);
        longint d;
        longint q;
        d = longint'(pix) * 16 - longint'(ctr);
        q = round_shift((d < 0 ? -d : d) * longint'(pupil_inv_r), 12);
        return d < 0 ? -q : q;
    endfunction

    // Zernike mode (n, m) in Cartesian form: radial polynomial in rho^2 times Re or Im of
    // (x + iy)^|m|, every product rounded back to Q16.
    function automatic longint zernike_q16(int n, int m, longint xn, longint yn, longint r2);
        int     a;
        int     half_span;
        longint re;
        longint im;
        longint nr;
        longint pw;
        longint poly;
        longint c;
        longint pows[20];
        a = m < 0 ? -m : m;
        half_span = (n - a) / 2;
        re = 65536;
        im = 0;
        pw = 65536;
        poly = 0;
        for (int i = 0; i < a; i++) begin
            nr = round_shift(re * xn - im * yn, 16);
            im = round_shift(re * yn + im * xn, 16);
            re = nr;
        end
        for (int i = 0; i <= half_span; i++) begin
            pows[i] = pw;
            pw = round_shift(pw * r2, 16);
        end
        for (int k = 0; k <= half_span; k++) begin
            c = factorial(n - k) / (factorial(k) * factorial((n + a) / 2 - k)
                * factorial((n - a) / 2 - k));
            if (k % 2 == 1) begin
                c = -c;
            end
            poly += c * pows[half_span - k];
        end
        return round_shift(poly * (m < 0 ? im : re), 16);
    endfunction

    // Expected result for one pixel under the current registers.
    function automatic zpc_pkg::t_out_item predict_correction(zpc_pkg::t_in_item px);
        zpc_pkg::t_out_item res;
        longint      xn;
        longint      yn;
        longint      rr;
        longint      acc;
        longint      ph;
        longint      cr;
        longint      ci;
        longint      x;
        longint      y;
        longint      z;
        longint      t;
        longint      xs;
        longint      ys;
        int          limit;
        int          count;
        logic        in_pupil;
        logic signed [15:0] coef;
        xn = pupil_coord(px.pixel_x, pupil_cx);
        yn = pupil_coord(px.pixel_y, pupil_cy);
        rr = xn * xn + yn * yn;
        in_pupil = rr <= (longint'(1) << 32);
        ph = 0;
        cr = px.field_real;
        ci = px.field_imag;
        if (in_pupil) begin
            acc = 0;
            count = 0;
            limit = modes_used > 16 ? 16 : int'(modes_used);
            for (int n = 0; n < 20 && count < limit; n++) begin
                for (int m = -n; m <= n && count < limit; m += 2) begin
                    coef = coeff_words[count / 4][16 * (count % 4) +: 16];
                    acc += longint'(coef) * zernike_q16(n, m, xn, yn, round_shift(rr, 16));
                    count++;
                end
            end
            ph = clip16(round_shift(acc, 16));
        end
        // A zero phase leaves the field untouched; otherwise rotate by -phase with CORDIC.
        if (ph != 0) begin
            x = cr * 65536;
            y = ci * 65536;
            z = -ph * 32;
            while (z > zpc_pkg::QUARTER_PI_Q16) begin
                t = x; x = -y; y = t; z -= zpc_pkg::HALF_PI_Q16;
            end
            while (z < -zpc_pkg::QUARTER_PI_Q16) begin
                t = x; x = y; y = -t; z += zpc_pkg::HALF_PI_Q16;
            end
            for (int i = 0; i < zpc_pkg::CORDIC_STEPS; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x -= ys; y += xs; z -= longint'(zpc_pkg::ATAN_TAB[i]);
                end else begin
                    x += ys; y -= xs; z += longint'(zpc_pkg::ATAN_TAB[i]);
                end
            end
            cr = clip16(round_shift(x * zpc_pkg::CORDIC_GAIN_INV, 32));
            ci = clip16(round_shift(y * zpc_pkg::CORDIC_GAIN_INV, 32));
        end
        res.corrected_real = 16'(cr);
        res.corrected_imag = 16'(ci);
        res.phase_value    = 16'(ph);
        res.inside_pupil   = in_pupil;
        return res;
    endfunction

    function automatic void note_mismatch(string what, longint got, longint want);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%t mismatch in %s: expected %0d, got %0d", $realtime, what, want, got);
        end
    endfunction

    // Result checker; the ready line is redrawn each cycle to model a stalling receiver.
    always @(posedge i_clk) begin : check_results
        zpc_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result count", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_out_item.corrected_real !== want.corrected_real) begin
                    note_mismatch("corrected_real", o_out_item.corrected_real,
                                  want.corrected_real);
                end
                if (o_out_item.corrected_imag !== want.corrected_imag) begin
                    note_mismatch("corrected_imag", o_out_item.corrected_imag,
                                  want.corrected_imag);
                end
                if (o_out_item.phase_value !== want.phase_value) begin
                    note_mismatch("phase_value", o_out_item.phase_value, want.phase_value);
                end
                if (o_out_item.inside_pupil !== want.inside_pupil) begin
                    note_mismatch("inside_pupil", o_out_item.inside_pupil, want.inside_pupil);
                end
            end
        end
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Hang detector: any handshake on any channel restarts the count.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == HANG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Sends one pixel item. Valid is only lowered when the sender decides to idle, so
    // back-to-back items keep it high. The prediction is queued at acceptance.
    task automatic send_pixel(zpc_pkg::t_in_item px);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do begin
                @(posedge i_clk);
            end while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= px;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        pending_results.insert(pending_results.size(), predict_correction(px));
    endtask

    // Stops sending and waits until every result is back and the pipeline is empty.
    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write; only issued while the block is idle. Valid is lowered for one
    // cycle after each write.
    task automatic write_reg(logic [3:0] idx, logic [63:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        case (idx)
            zpc_pkg::CFG_CENTER_X:   pupil_cx    = value[13:0];
            zpc_pkg::CFG_CENTER_Y:   pupil_cy    = value[13:0];
            zpc_pkg::CFG_INV_RADIUS: pupil_inv_r = value[23:0];
            zpc_pkg::CFG_MODE_COUNT: modes_used  = value[4:0];
            zpc_pkg::CFG_COEFF_0:    coeff_words[0] = value;
            zpc_pkg::CFG_COEFF_1:    coeff_words[1] = value;
            zpc_pkg::CFG_COEFF_2:    coeff_words[2] = value;
            zpc_pkg::CFG_COEFF_3:    coeff_words[3] = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic zpc_pkg::t_in_item make_pixel(int px, int py, int fr, int fi);
        zpc_pkg::t_in_item it;
        it.pixel_x    = 10'(px);
        it.pixel_y    = 10'(py);
        it.field_real = 16'(fr);
        it.field_imag = 16'(fi);
        return it;
    endfunction

    // Four random Q4.11 coefficients; mostly within about a radian, sometimes any value.
    function automatic logic [63:0] random_coeff_word();
        logic [63:0] w;
        for (int f = 0; f < 4; f++) begin
            if ($urandom_range(0, 3) == 0) begin
                w[16 * f +: 16] = 16'($urandom);
            end else begin
                w[16 * f +: 16] = 16'(int'($urandom_range(0, 4096)) - 2048);
            end
        end
        return w;
    endfunction

    // Register defaults after reset: a 512-pixel pupil at the image center and no modes,
    // so every pixel must pass through unchanged with the pupil flag set correctly.
    task automatic test_reset_defaults();
        send_pixel(make_pixel(512, 512, 32767, -32768));
        send_pixel(make_pixel(0, 0, -32768, 32767));
        send_pixel(make_pixel(1023, 1023, 1234, -4321));
        send_pixel(make_pixel(0, 512, 0, 0));
        send_pixel(make_pixel(1023, 512, -1, 1));
        drain_pipeline();
    endtask

    // Directed corners: a pure piston drives the phase to its extremes (many quarter
    // turns in the rotation), a full sixteen-mode set, a too-large mode count, a zero
    // reciprocal radius and a write to an index with no register behind it.
    task automatic test_directed_cases();
        write_reg(zpc_pkg::CFG_CENTER_X, 64'd0);
        write_reg(zpc_pkg::CFG_CENTER_Y, 64'd16383);
        write_reg(zpc_pkg::CFG_INV_RADIUS, 64'hFFFFFF);
        write_reg(zpc_pkg::CFG_MODE_COUNT, 64'd1);
        write_reg(zpc_pkg::CFG_COEFF_0, 64'h0000_0000_0000_8000);
        send_pixel(make_pixel(0, 1023, 32767, 32767));
        send_pixel(make_pixel(0, 1022, -32768, -32768));
        send_pixel(make_pixel(1, 1023, 100, -100));
        drain_pipeline();
        write_reg(zpc_pkg::CFG_COEFF_0, 64'h0000_0000_0000_7FFF);
        write_reg(zpc_pkg::CFG_INV_RADIUS, 64'd0);
        send_pixel(make_pixel(1023, 0, 32767, -32768));
        send_pixel(make_pixel(512, 512, -32768, 0));
        drain_pipeline();
        write_reg(zpc_pkg::CFG_CENTER_X, 64'd8192);
        write_reg(zpc_pkg::CFG_CENTER_Y, 64'd8192);
        write_reg(zpc_pkg::CFG_INV_RADIUS, 64'd41943);
        write_reg(zpc_pkg::CFG_MODE_COUNT, 64'd16);
        write_reg(zpc_pkg::CFG_COEFF_0, 64'h0400_FC00_0200_0100);
        write_reg(zpc_pkg::CFG_COEFF_1, 64'hFF00_0300_FD00_0080);
        write_reg(zpc_pkg::CFG_COEFF_2, 64'h0180_FE80_0240_FF40);
        write_reg(zpc_pkg::CFG_COEFF_3, 64'hFFC0_0140_FEC0_00C0);
        write_reg(UNMAPPED_REG, 64'hFFFF_FFFF_FFFF_FFFF);
        send_pixel(make_pixel(512, 512, 20000, -20000));
        send_pixel(make_pixel(912, 512, 30000, 5000));
        send_pixel(make_pixel(512, 112, -30000, 12000));
        send_pixel(make_pixel(800, 250, 32767, 32767));
        send_pixel(make_pixel(300, 700, -32768, -32768));
        send_pixel(make_pixel(0, 0, 5, 5));
        drain_pipeline();
        write_reg(zpc_pkg::CFG_MODE_COUNT, 64'd31);
        send_pixel(make_pixel(700, 400, 16000, -8000));
        send_pixel(make_pixel(420, 610, -123, 4567));
        drain_pipeline();
    endtask

    // Random pupils and coefficient sets; most pixels fall near the pupil, the rest anywhere.
    task automatic test_random_pixels(int configs, int per_config);
        int radius;
        int cx;
        int cy;
        int px;
        int py;
        for (int c = 0; c < configs; c++) begin
            radius = $urandom_range(4, 700);
            write_reg(zpc_pkg::CFG_CENTER_X, 64'($urandom_range(0, 16383)));
            write_reg(zpc_pkg::CFG_CENTER_Y, 64'($urandom_range(0, 16383)));
            if ($urandom_range(0, 7) == 0) begin
                write_reg(zpc_pkg::CFG_INV_RADIUS, 64'($urandom_range(0, 24'hFFFFFF)));
            end else begin
                write_reg(zpc_pkg::CFG_INV_RADIUS, 64'((1 << 24) / radius));
            end
            write_reg(zpc_pkg::CFG_MODE_COUNT, 64'($urandom_range(0, 20)));
            write_reg(zpc_pkg::CFG_COEFF_0, random_coeff_word());
            write_reg(zpc_pkg::CFG_COEFF_1, random_coeff_word());
            write_reg(zpc_pkg::CFG_COEFF_2, random_coeff_word());
            write_reg(zpc_pkg::CFG_COEFF_3, random_coeff_word());
            cx = pupil_cx / 16;
            cy = pupil_cy / 16;
            for (int i = 0; i < per_config; i++) begin
                if ($urandom_range(0, 9) < 7) begin
                    px = cx + int'($urandom_range(0, 2 * radius)) - radius;
                    py = cy + int'($urandom_range(0, 2 * radius)) - radius;
                    px = px < 0 ? 0 : (px > 1023 ? 1023 : px);
                    py = py < 0 ? 0 : (py > 1023 ? 1023 : py);
                end else begin
                    px = $urandom_range(0, 1023);
                    py = $urandom_range(0, 1023);
                end
                send_pixel(make_pixel(px, py, $urandom, $urandom));
            end
            drain_pipeline();
        end
    endtask

    initial begin
        pupil_cx    = 14'd8192;
        pupil_cy    = 14'd8192;
        pupil_inv_r = 24'd32768;
        modes_used  = '0;
        coeff_words = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed_cases();

        // Slow sender with a mostly stalled receiver, then the reverse, then full rate.
        send_idle_pct = 26;
        recv_idle_pct = 88;
        test_random_pixels(3, 170);
        send_idle_pct = 88;
        recv_idle_pct = 26;
        test_random_pixels(3, 170);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_pixels(3, 170);

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### files.f
rtl/zpc_pkg.sv
rtl/zpc_phase.sv
rtl/zpc_cordic.sv
rtl/zernike_phase_correction.sv
rtl/zpc_checker.sv
verif/tb.sv
